/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ITR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("itr assertion failed");
// expression must never be true outside reset
`define ITR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("itr forbidden condition seen");
`else
`define ITR_ASSERT(lbl, clk, rst_n, prop)
`define ITR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* hw/rtl/itr_pkg.sv */
// ----------------------------------------------------------------------------
// itr_pkg
// Shared constants, types and the digit to ASCII mapping of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itr_pkg;

	// defaults and fixed widths
	localparam int WORD_BITS_DEF = 32;
	localparam int RADIX_W       = 6;
	localparam int CHAR_W        = 7;
	localparam int STEP_BITS     = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPA   = 7'h41;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // take a new request, reset the division chain
		logic div_step;   // run one slice of the divider
		logic load_sign;  // put the minus sign in the output register
		logic rd_req;     // read the next stored digit, most significant first
		logic load_char;  // put the digit just read in the output register
	} itr_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_last;   // this divider slice finishes one digit
		logic quo_zero;   // quotient after this slice is zero
		logic sign_ten;   // negative value in radix ten
		logic char_last;  // output register holds the final character
	} itr_status_t;

	// digit value to ASCII, letters above nine
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DIGIT_MAX) begin
			c = CHAR_UPA + {1'b0, d} - {1'b0, RADIX_DEC};
		end else begin
			c = CHAR_ZERO + {1'b0, d};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/itr_ram.sv */
// ----------------------------------------------------------------------------
// itr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/itr_ctrl.sv */
// ----------------------------------------------------------------------------
// itr_ctrl
// Sequencer: accept, divide into digits, optional sign, then emit digits.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	output      logic                out_valid,
	input  wire logic                out_ready,
	input  wire itr_pkg::itr_status_t st,
	output      itr_pkg::itr_cmd_t   cmd
);

	import itr_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_SIGN = 6'b000100,
		S_READ = 6'b001000,
		S_LOAD = 6'b010000,
		S_EMIT = 6'b100000
	} itr_state_t;

	itr_state_t state_q;
	itr_state_t state_d;

	// handshake outputs come straight from the state register
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SIGN) || (state_q == S_EMIT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last && st.quo_zero) begin
					if (st.sign_ten) begin
						cmd.load_sign = 1'b1;
						state_d       = S_SIGN;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_SIGN: begin
				if (out_ready) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_req = 1'b1;
				state_d    = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_char = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (out_ready) begin
					state_d = st.char_last ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/itr_dp.sv */
// ----------------------------------------------------------------------------
// itr_dp
// Datapath: radix register, sliced divider, digit store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_dp #(
	parameter int WORD_BITS = itr_pkg::WORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [itr_pkg::RADIX_W-1:0]   cfg_data,
	input  wire logic                          mode,
	input  wire logic [WORD_BITS-1:0]          word_in,
	input  wire itr_pkg::itr_cmd_t             cmd,
	output      itr_pkg::itr_status_t          st,
	output      logic [itr_pkg::CHAR_W-1:0]    char_out,
	output      logic                          last_char
);

	import itr_pkg::*;

	localparam int DIV_STEPS = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_BITS  = DIV_STEPS * STEP_BITS;
	localparam int STEP_CW   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int ADDR_W    = $clog2(WORD_BITS);
	localparam logic [STEP_CW-1:0] STEP_LAST = STEP_CW'(DIV_STEPS - 1);

	logic [RADIX_W-1:0]   radix_q;
	logic [RADIX_W-1:0]   eff_radix_q;
	logic [RADIX_W-1:0]   eff_radix;
	logic                 sign_ten_q;
	logic [PAD_BITS-1:0]  quo_q;
	logic [PAD_BITS-1:0]  quo_nx;
	logic [RADIX_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   rem_nx;
	logic [STEP_BITS-1:0] qbits;
	logic [STEP_CW-1:0]   step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_m1;
	logic                 neg;
	logic [WORD_BITS-1:0] mag;
	logic                 div_last;
	logic [RADIX_W-1:0]   rd_digit;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	// radix register, written from the configuration channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	// clamp the radix to 2..36
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	// magnitude of the incoming word
	assign neg = !mode && word_in[WORD_BITS-1];
	assign mag = neg ? (~word_in + WORD_BITS'(1)) : word_in;

	// one slice of restoring division, STEP_BITS quotient bits
	always_comb begin
		logic [RADIX_W:0] part;
		logic [RADIX_W-1:0] rem_v;
		rem_v = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			part = {rem_v, quo_q[PAD_BITS-1-i]};
			if (part >= {1'b0, eff_radix_q}) begin
				part                    = part - {1'b0, eff_radix_q};
				qbits[STEP_BITS-1-i]    = 1'b1;
			end
			rem_v = part[RADIX_W-1:0];
		end
		rem_nx = rem_v;
		quo_nx = (quo_q << STEP_BITS) | PAD_BITS'(qbits);
	end

	assign div_last = (step_q == STEP_LAST);
	assign cnt_m1   = cnt_q - CNT_W'(1);

	// divider state and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			quo_q  <= PAD_BITS'(mag);
			rem_q  <= '0;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_nx;
			if (div_last) begin
				rem_q  <= '0;
				step_q <= '0;
				cnt_q  <= cnt_q + CNT_W'(1);
			end else begin
				rem_q  <= rem_nx;
				step_q <= step_q + STEP_CW'(1);
			end
		end else if (cmd.rd_req) begin
			cnt_q <= cnt_m1;
		end
	end

	// request attributes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			eff_radix_q <= eff_radix;
			sign_ten_q  <= neg && (eff_radix == RADIX_DEC);
		end
	end

	// digit store, least significant digit at address zero
	itr_ram #(
		.WIDTH(RADIX_W),
		.DEPTH(WORD_BITS)
	) u_digits (
		.clk  (clk),
		.we   (cmd.div_step && div_last),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(rem_nx),
		.re   (cmd.rd_req),
		.raddr(cnt_m1[ADDR_W-1:0]),
		.rdata(rd_digit)
	);

	// output character register
	always_ff @(posedge clk) begin
		if (cmd.load_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.load_char) begin
			char_q <= digit_char(rd_digit);
			last_q <= (cnt_q == '0);
		end
	end

	assign char_out  = char_q;
	assign last_char = last_q;

	// status
	assign st.div_last  = div_last;
	assign st.quo_zero  = (quo_nx == '0);
	assign st.sign_ten  = sign_ten_q;
	assign st.char_last = last_q;

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a word to ASCII digits in a radix from 2 to 36, most significant
// digit first, with a minus sign for negative values in radix ten.
//
//   channel  direction  payload               handshake
//   in       input      mode, word_in         in_valid / in_ready
//   out      output     char_out, last_char   out_valid / out_ready
//   cfg      input      cfg_data (radix)      cfg_valid / cfg_ready
//
// One request at a time: in_ready is high only while nothing is in flight.
// The divider retires eight quotient bits per cycle and works through the
// whole padded word for each digit. Each character then passes through
// store read, load and present, and waits in present while out_ready is low;
// the sign, when there is one, is presented first and can stall the same way.
// Reset sets the radix to ten and leaves the digit store uninitialized.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_to_ascii_radix #(
	parameter int WORD_BITS = itr_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [itr_pkg::RADIX_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        mode,
	input  wire logic [WORD_BITS-1:0]        word_in,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [itr_pkg::CHAR_W-1:0]  char_out,
	output      logic                        last_char
);

	import itr_pkg::*;

	itr_cmd_t    cmd;
	itr_status_t st;

	// radix writes are taken at any time
	assign cfg_ready = 1'b1;

	// sequencer
	itr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	itr_dp #(
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.mode     (mode),
		.word_in  (word_in),
		.cmd      (cmd),
		.st       (st),
		.char_out (char_out),
		.last_char(last_char)
	);

	// checks
	`ITR_ASSERT_NEVER(a_no_overlap, clk, arst_n, in_ready && out_valid)
	`ITR_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	`ITR_ASSERT(a_idle_after_last, clk, arst_n, (out_valid && out_ready && last_char) |=> in_ready)
	`ITR_ASSERT(a_legal_char, clk, arst_n, out_valid |-> ((char_out == CHAR_MINUS) || ((char_out >= CHAR_ZERO) && (char_out <= 7'h39)) || ((char_out >= CHAR_UPA) && (char_out <= 7'h5A))))

endmodule

`default_nettype wire

/* verif/tb_integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix
// Self-checking bench for the radix converter. Requests of mode and word are
// offered in random bursts, the character stream is checked against a local
// model of the conversion, and the radix is rewritten between phases.
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_radix;

	import itr_pkg::*;

	localparam int WB             = WORD_BITS_DEF;
	localparam int IDLE_PAD       = 8;
	localparam int END_PAD        = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 32;
	localparam int LONG_HOLD      = 400;

	localparam logic MODE_SIGNED   = 1'b0;
	localparam logic MODE_UNSIGNED = 1'b1;

	typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_rec_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RADIX_W-1:0]  cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                mode      = MODE_SIGNED;
	logic [WB-1:0]       word_in   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CHAR_W-1:0]   char_out;
	logic                last_char;

	// local copy of the radix register and the expected character stream
	logic [RADIX_W-1:0]  radix_reg = RADIX_RESET;
	char_rec_t           expected_chars[$];
	char_rec_t           head_char;
	int                  error_count = 0;

	// receiver and sender pacing state
	int                  hold_len     = 0;
	int                  hold_cnt     = 0;
	int                  stretch_left = 0;
	rx_mode_t            rx_mode      = RX_ALWAYS;
	int                  burst_left   = 0;
	int                  idle_cycles  = 0;

	integer_to_ascii_radix uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.word_in   (word_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last_char (last_char)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [RADIX_W-1:0] d);
		if (d > DIGIT_MAX)
			return CHAR_UPA + CHAR_W'(d - RADIX_DEC);
		return CHAR_ZERO + CHAR_W'(d);
	endfunction

	// expected characters of one request, most significant digit first
	task automatic predict_string(input logic m, input logic [WB-1:0] w);
		logic [RADIX_W-1:0] base;
		logic [WB-1:0]      quo;
		logic [WB-1:0]      mag;
		logic               neg;
		logic [RADIX_W-1:0] digits [WB];
		int                 n;
		int                 i;
		if (radix_reg < RADIX_MIN)
			base = RADIX_MIN;
		else if (radix_reg > RADIX_MAX)
			base = RADIX_MAX;
		else
			base = radix_reg;
		neg = (m == MODE_SIGNED) && w[WB-1];
		mag = neg ? (~w + 1'b1) : w;
		if (neg && base == RADIX_DEC)
			expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
		quo = mag;
		n = 0;
		do begin
			digits[n] = RADIX_W'(quo % WB'(base));
			n++;
			quo = quo / WB'(base);
		end while (quo != '0);
		for (i = n - 1; i >= 0; i--)
			expected_chars.push_back('{ch: ascii_digit(digits[i]), last: (i == 0)});
	endtask

	// offer one request and hold it until accepted
	task automatic offer_word(input logic m, input logic [WB-1:0] w);
		in_valid <= 1'b1;
		mode     <= m;
		word_in  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_string(m, w);
	endtask

	// burst and gap pacing of the sender
	task automatic sender_pace();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_paced(input logic m, input logic [WB-1:0] w);
		offer_word(m, w);
		sender_pace();
	endtask

	// stop offering and wait until every expected character has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	// radix write, only while the block is idle
	task automatic write_radix(input logic [RADIX_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		radix_reg = value;
	endtask

	// random word biased toward the edges of the range
	function automatic logic [WB-1:0] pick_word();
		case ($urandom_range(0, 6))
			0, 1:    return WB'($urandom);
			2:       return WB'($urandom_range(0, 1000));
			3:       return {WB{1'b1}} - WB'($urandom_range(0, 1000));
			4:       return {1'b1, {(WB-1){1'b0}}} + WB'($urandom_range(0, 3));
			5:       return {1'b0, {(WB-1){1'b1}}} - WB'($urandom_range(0, 3));
			default: return WB'(1) << $urandom_range(0, WB - 1);
		endcase
	endfunction

	// extremes at the reset radix of ten
	task automatic test_reset_radix();
		send_paced(MODE_SIGNED,   '0);
		send_paced(MODE_UNSIGNED, '0);
		send_paced(MODE_SIGNED,   WB'(1));
		send_paced(MODE_SIGNED,   {WB{1'b1}});
		send_paced(MODE_UNSIGNED, {WB{1'b1}});
		send_paced(MODE_SIGNED,   {1'b1, {(WB-1){1'b0}}});
		send_paced(MODE_UNSIGNED, {1'b1, {(WB-1){1'b0}}});
		send_paced(MODE_SIGNED,   {1'b0, {(WB-1){1'b1}}});
	endtask

	// smallest and largest radix, and register values outside 2..36
	task automatic test_radix_extremes();
		write_radix(RADIX_MIN);
		send_paced(MODE_UNSIGNED, {WB{1'b1}});
		send_paced(MODE_SIGNED,   {1'b1, {(WB-1){1'b0}}});
		send_paced(MODE_SIGNED,   {WB{1'b1}});
		write_radix(RADIX_MAX);
		send_paced(MODE_UNSIGNED, {WB{1'b1}});
		send_paced(MODE_UNSIGNED, WB'(35));
		send_paced(MODE_SIGNED,   {1'b1, {(WB-1){1'b0}}});
		write_radix(RADIX_W'(0));
		send_paced(MODE_UNSIGNED, WB'(5));
		write_radix(RADIX_W'(1));
		send_paced(MODE_SIGNED,   WB'(-6));
		write_radix(RADIX_W'(37));
		send_paced(MODE_UNSIGNED, WB'(36 * 36 - 1));
		write_radix({RADIX_W{1'b1}});
		send_paced(MODE_SIGNED,   {WB{1'b1}});
	endtask

	// long output stall while requests keep coming
	task automatic test_output_backpressure();
		int k;
		write_radix(RADIX_DEC);
		hold_len = LONG_HOLD;
		for (k = 0; k < 4; k++)
			offer_word(MODE_SIGNED, pick_word());
		wait_drained();
	endtask

	// sender pauses until the stream has fully drained
	task automatic test_pause_until_drained();
		int k;
		for (k = 0; k < 3; k++)
			send_paced(k[0], pick_word());
		wait_drained();
		for (k = 0; k < 3; k++)
			send_paced(k[0], pick_word());
	endtask

	// random requests over several radix settings
	task automatic test_random_items();
		int plan [6] = '{10, 16, 2, 36, 8, 3};
		int p;
		int k;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 6)
				write_radix(RADIX_W'(plan[p]));
			else
				write_radix(RADIX_W'($urandom_range(0, 63)));
			for (k = 0; k < PHASE_ITEMS; k++)
				send_paced(logic'($urandom_range(0, 1)), pick_word());
		end
	endtask

	// receiver ready pattern, with an optional long hold
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_cnt = hold_len;
			hold_len = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			if (stretch_left <= 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				stretch_left = $urandom_range(5, 60);
			end
			stretch_left--;
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_HALF:   out_ready <= logic'($urandom_range(0, 1));
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				default:   out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare each character against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected character %h last %b", char_out, last_char);
			end else begin
				head_char = expected_chars.pop_front();
				if (char_out !== head_char.ch || last_char !== head_char.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("mismatch: expected char %h last %b, got char %h last %b",
							head_char.ch, head_char.last, char_out, last_char);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_extremes();
		test_output_backpressure();
		test_pause_until_drained();
		test_random_items();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (END_PAD) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/itr_pkg.sv
hw/rtl/itr_ram.sv
hw/rtl/itr_ctrl.sv
hw/rtl/itr_dp.sv
hw/rtl/integer_to_ascii_radix.sv
verif/tb_integer_to_ascii_radix.sv
